// File: sv/hcmg_pkg.sv
// ----------------------------------------------------------------------------
// hcmg_pkg
// Shared types, constants and lookup tables of the Hilbert curve move
// generator: curve patterns, move directions and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package hcmg_pkg;

	localparam int MaxOrder  = 16;
	localparam int OrderW    = 5;
	localparam int DepthW    = 5;
	localparam int IdxW      = 4;
	localparam int SideW     = 32;
	localparam int MoveW     = 33;
	localparam int InDataW   = 8;
	localparam int OutDataW  = 72;
	localparam int OutUserW  = 2;
	localparam int CfgIdxW   = 1;

	localparam logic [SideW-1:0] SideReset = 32'h0001_0000;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_CURVE_ORDER = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_SIDE_LENGTH = 1'b1;

	// Bit positions inside the result tuser.
	localparam int UserRelBit  = 0;
	localparam int UserPastBit = 1;

	typedef enum logic [1:0] {
		PAT_A = 2'd0,
		PAT_B = 2'd1,
		PAT_C = 2'd2,
		PAT_D = 2'd3
	} pattern_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		DP_NOP     = 3'd0,
		DP_START   = 3'd1,
		DP_POP     = 3'd2,
		DP_PASTEND = 3'd3,
		DP_MOVE    = 3'd4,
		DP_PUSH    = 3'd5
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic ord_zero;
		logic pop_top;
		logic move_ok;
		logic last_move;
		logic push_ok;
		logic out_free;
	} dp_sts_t;

	// Pattern of the sub-square entered after a given number of moves.
	function automatic pattern_t child_pattern(input pattern_t p, input logic [1:0] k);
		logic [7:0] row;
		unique case (p)
			PAT_A: row = {PAT_C, PAT_A, PAT_A, PAT_B};
			PAT_B: row = {PAT_D, PAT_B, PAT_B, PAT_A};
			PAT_C: row = {PAT_A, PAT_C, PAT_C, PAT_D};
			PAT_D: row = {PAT_B, PAT_D, PAT_D, PAT_C};
			default: row = '0;
		endcase
		return pattern_t'(row[{k, 1'b0} +: 2]);
	endfunction

	// Direction of the k-th connecting move of a pattern; a full phase
	// repeats the last move.
	function automatic dir_t move_direction(input pattern_t p, input logic [1:0] k);
		logic [5:0] row;
		logic [1:0] kk;
		kk = (k == 2'd3) ? 2'd2 : k;
		unique case (p)
			PAT_A: row = {DIR_DOWN, DIR_RIGHT, DIR_UP};
			PAT_B: row = {DIR_LEFT, DIR_UP, DIR_RIGHT};
			PAT_C: row = {DIR_RIGHT, DIR_DOWN, DIR_LEFT};
			PAT_D: row = {DIR_UP, DIR_LEFT, DIR_DOWN};
			default: row = '0;
		endcase
		return dir_t'(row[{kk, 1'b0} +: 2]);
	endfunction

endpackage

`default_nettype wire

// File: sv/hcmg_ctrl.sv
// ----------------------------------------------------------------------------
// hcmg_ctrl
// Controller of the move generator: takes one request at a time and steps
// the datapath through a restart, stack pops, the move itself or a past-end
// beat, stack pushes and the hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcmg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_restart,
	output logic                   req_ready,
	input  wire hcmg_pkg::dp_sts_t sts,
	output hcmg_pkg::dp_cmd_t      cmd
);
	import hcmg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_POP  = 4'b0010,
		ST_PUSH = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.op       = DP_NOP;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_restart) begin
						cmd.op  = DP_START;
						state_d = sts.ord_zero ? ST_EMIT : ST_PUSH;
					end else begin
						state_d = ST_POP;
					end
				end
			end
			ST_POP: begin
				// Finished levels are dropped one per cycle before the move.
				priority if (sts.pop_top) begin
					cmd.op = DP_POP;
				end else if (!sts.move_ok) begin
					cmd.op  = DP_PASTEND;
					state_d = ST_EMIT;
				end else begin
					cmd.op  = DP_MOVE;
					state_d = sts.last_move ? ST_EMIT : ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (sts.push_ok) begin
					cmd.op = DP_PUSH;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/hcmg_dp.sv
// ----------------------------------------------------------------------------
// hcmg_dp
// Datapath of the move generator: configuration registers, the pattern and
// phase stack, cell length, the staged result and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcmg_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [hcmg_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire logic [hcmg_pkg::SideW-1:0]         cfg_data,
	input  wire hcmg_pkg::dp_cmd_t                  cmd,
	output hcmg_pkg::dp_sts_t                       sts,
	input  wire logic                               out_ready,
	output logic                                    out_valid,
	output logic signed [hcmg_pkg::MoveW-1:0]       out_x,
	output logic signed [hcmg_pkg::MoveW-1:0]       out_y,
	output logic                                    out_rel,
	output logic                                    out_last,
	output logic                                    out_past
);
	import hcmg_pkg::*;

	logic [OrderW-1:0] curve_order_q;
	logic [SideW-1:0]  side_length_q;

	pattern_t          pat_q [MaxOrder];
	logic [1:0]        ph_q  [MaxOrder];
	logic [DepthW-1:0] depth_q;
	logic              done_q;

	logic [MoveW-1:0]  res_x_q, res_y_q;
	logic              res_rel_q, res_last_q, res_past_q;
	logic              out_valid_q;

	logic [OrderW-1:0] ord;
	logic [SideW-1:0]  cell_len;
	logic [MoveW-1:0]  cell_pos, cell_neg;
	logic [IdxW-1:0]   top;
	logic [IdxW-1:0]   wr_idx;
	pattern_t          top_pat;
	logic [1:0]        top_ph;
	logic              depth_nz;
	dir_t              dir;

	assign ord      = (curve_order_q > OrderW'(MaxOrder)) ? OrderW'(MaxOrder) : curve_order_q;
	assign cell_len = side_length_q >> ord;
	assign cell_pos = {1'b0, cell_len};
	assign cell_neg = MoveW'(0) - cell_pos;
	assign top      = IdxW'(depth_q - DepthW'(1));
	assign wr_idx   = depth_q[IdxW-1:0];
	assign top_pat  = pat_q[top];
	assign top_ph   = ph_q[top];
	assign depth_nz = (depth_q != '0);
	assign dir      = move_direction(top_pat, top_ph);

	assign sts.ord_zero  = (ord == '0);
	assign sts.pop_top   = !done_q && depth_nz && (top_ph == 2'd3);
	assign sts.move_ok   = !done_q && depth_nz;
	assign sts.last_move = (depth_q == DepthW'(1)) && (top_ph == 2'd2);
	assign sts.push_ok   = depth_nz && (depth_q < DepthW'(ord)) && (depth_q < DepthW'(MaxOrder));
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_order_q <= '0;
			side_length_q <= SideReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CURVE_ORDER: curve_order_q <= cfg_data[OrderW-1:0];
				REG_SIDE_LENGTH: side_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxOrder; i++) begin
				pat_q[i] <= PAT_A;
				ph_q[i]  <= 2'd0;
			end
			depth_q <= '0;
			done_q  <= 1'b1;
		end else begin
			unique case (cmd.op)
				DP_START: begin
					if (sts.ord_zero) begin
						depth_q <= '0;
						done_q  <= 1'b1;
					end else begin
						pat_q[0] <= PAT_A;
						ph_q[0]  <= 2'd0;
						depth_q  <= DepthW'(1);
						done_q   <= 1'b0;
					end
				end
				DP_POP:     depth_q <= depth_q - DepthW'(1);
				DP_PASTEND: done_q <= 1'b1;
				DP_MOVE: begin
					ph_q[top] <= top_ph + 2'd1;
					if (sts.last_move) begin
						done_q <= 1'b1;
					end
				end
				DP_PUSH: begin
					pat_q[wr_idx] <= child_pattern(top_pat, top_ph);
					ph_q[wr_idx]  <= 2'd0;
					depth_q       <= depth_q + DepthW'(1);
				end
				default: ;
			endcase
		end
	end

	// Result staged while the previous beat may still wait at the output.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_START: begin
				res_x_q    <= MoveW'(cell_len >> 1);
				res_y_q    <= MoveW'(cell_len >> 1);
				res_rel_q  <= 1'b0;
				res_last_q <= sts.ord_zero;
				res_past_q <= 1'b0;
			end
			DP_PASTEND: begin
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_rel_q  <= 1'b1;
				res_last_q <= 1'b0;
				res_past_q <= 1'b1;
			end
			DP_MOVE: begin
				res_x_q    <= (dir == DIR_RIGHT) ? cell_pos : (dir == DIR_LEFT) ? cell_neg : '0;
				res_y_q    <= (dir == DIR_UP) ? cell_pos : (dir == DIR_DOWN) ? cell_neg : '0;
				res_rel_q  <= 1'b1;
				res_last_q <= sts.last_move;
				res_past_q <= 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_x    <= res_x_q;
			out_y    <= res_y_q;
			out_rel  <= res_rel_q;
			out_last <= res_last_q;
			out_past <= res_past_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: sv/hilbert_curve_move_generator_top.sv
// ----------------------------------------------------------------------------
// hilbert_curve_move_generator_top
// Hilbert curve vertex generator: start vertex on restart, then one scaled
// unit move per request, with last and past-end flags.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A restart beat fills the level
// stack down to the curve order before it returns the start vertex. A move
// beat drops finished levels, makes the move and enters new levels; the last
// move and a past-end beat enter no new levels. Levels are dropped and
// entered one per cycle through the single pattern/phase stack port. The
// result sits in an output register and the next request is taken while
// it waits there. Write the configuration only while no request is in
// flight.
`default_nettype none

module hilbert_curve_move_generator_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration write channel.
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [hcmg_pkg::CfgIdxW-1:0]        cfg_index,
	input  wire logic [hcmg_pkg::SideW-1:0]          cfg_data,
	// Request stream.
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [hcmg_pkg::InDataW-1:0]        s_tdata,  // [0] restart, rest zero
	// Result stream.
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [hcmg_pkg::OutDataW-1:0]            m_tdata,  // [32:0] move_x, [65:33] move_y
	output logic [hcmg_pkg::OutUserW-1:0]            m_tuser,  // [0] is_relative, [1] past_end
	output logic                                     m_tlast   // is_last
);
	import hcmg_pkg::*;

	dp_cmd_t                 cmd;
	dp_sts_t                 sts;
	logic signed [MoveW-1:0] out_x, out_y;
	logic                    out_rel, out_last, out_past;

	assign cfg_ready = 1'b1;

	hcmg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_tvalid),
		.req_restart (s_tdata[0]),
		.req_ready   (s_tready),
		.sts         (sts),
		.cmd         (cmd)
	);

	hcmg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_rel   (out_rel),
		.out_last  (out_last),
		.out_past  (out_past)
	);

	assign m_tdata = {{(OutDataW - 2 * MoveW){1'b0}}, out_y, out_x};
	assign m_tuser = {out_past, out_rel};
	assign m_tlast = out_last;

	// One request in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// A pending result beat is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("output register loaded while still full");

	// Stack only grows within the configured order.
	a_push_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_PUSH |-> sts.push_ok)
		else $error("stack push beyond the curve order");

	// A past-end beat carries a zero move and is never the last vertex.
	a_past_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[UserPastBit] |-> !m_tlast && (m_tdata == '0))
		else $error("past-end beat with a move or last flag");

endmodule

`default_nettype wire

// File: dv/hilbert_curve_move_generator_top_tb.sv
// ----------------------------------------------------------------------------
// hilbert_curve_move_generator_top_tb
// Self-checking bench for the Hilbert curve move generator. A request queue
// feeds a stream driver, an in-bench walk of the pattern/phase stack predicts
// every vertex, and a monitor compares each result beat field by field.
// Directed curves cover order zero, clamped orders, extreme side lengths and
// a configuration change mid-curve; random phases then run full and partial
// curves with noise under random idling and back-pressure.
// ----------------------------------------------------------------------------

module hilbert_curve_move_generator_top_tb;

	import hcmg_pkg::*;

	localparam int SettleCycles = 2 * MaxOrder + 8;
	localparam int LongHold     = 400;
	localparam int RandomItems  = 750;

	typedef struct packed {
		logic [MoveW-1:0] x;
		logic [MoveW-1:0] y;
		logic             rel;
		logic             last;
		logic             past;
	} vertex_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [SideW-1:0]    cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic [OutUserW-1:0] m_tuser;
	logic                m_tlast;

	// Bench copy of the configuration and of the walk state.
	logic [OrderW-1:0] cur_order = '0;
	logic [SideW-1:0]  side_len  = SideReset;
	pattern_t          pat_stk [MaxOrder];
	logic [1:0]        ph_stk  [MaxOrder];
	int                lvl_count = 0;
	logic              walk_done = 1'b1;

	logic    restart_q [$];
	vertex_t pending_vertices [$];
	int      error_count = 0;

	logic tx_idle       = 1'b0;
	logic rx_idle       = 1'b0;
	logic long_hold_arm = 1'b0;
	logic long_hold_ack = 1'b0;
	int   tx_gap        = 0;
	int   rx_wait       = 0;
	int   rx_draw       = 0;

	hilbert_curve_move_generator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < MaxOrder; i++) begin
			pat_stk[i] = PAT_A;
			ph_stk[i]  = 2'd0;
		end
	end

	// Enter sub-squares until the stack is as deep as the order allows.
	function automatic void descend(input logic [OrderW-1:0] lim);
		pattern_t parent;
		logic [1:0] k;
		pattern_t child;
		while (lvl_count > 0 && lvl_count < int'(lim) && lvl_count < MaxOrder) begin
			parent = pat_stk[lvl_count-1];
			k      = ph_stk[lvl_count-1];
			case (parent)
				PAT_A: child = (k == 2'd0) ? PAT_B : (k == 2'd3) ? PAT_C : PAT_A;
				PAT_B: child = (k == 2'd0) ? PAT_A : (k == 2'd3) ? PAT_D : PAT_B;
				PAT_C: child = (k == 2'd0) ? PAT_D : (k == 2'd3) ? PAT_A : PAT_C;
				default: child = (k == 2'd0) ? PAT_C : (k == 2'd3) ? PAT_B : PAT_D;
			endcase
			pat_stk[lvl_count] = child;
			ph_stk[lvl_count]  = 2'd0;
			lvl_count++;
		end
	endfunction

	function automatic vertex_t next_vertex(input logic restart);
		vertex_t v;
		logic [OrderW-1:0] ord;
		logic [MoveW-1:0] cell_len;
		logic [1:0] k;
		dir_t d;
		ord      = (cur_order > OrderW'(MaxOrder)) ? OrderW'(MaxOrder) : cur_order;
		cell_len = {1'b0, side_len >> ord};
		v        = '0;
		if (restart) begin
			v.x = cell_len >> 1;
			v.y = cell_len >> 1;
			if (ord == '0) begin
				lvl_count = 0;
				walk_done = 1'b1;
				v.last    = 1'b1;
			end else begin
				pat_stk[0] = PAT_A;
				ph_stk[0]  = 2'd0;
				lvl_count  = 1;
				descend(ord);
				walk_done  = 1'b0;
			end
			return v;
		end
		// Drop levels whose three connecting moves are all done.
		while (!walk_done && lvl_count > 0 && ph_stk[lvl_count-1] == 2'd3)
			lvl_count--;
		v.rel = 1'b1;
		if (walk_done || lvl_count == 0) begin
			walk_done = 1'b1;
			v.past    = 1'b1;
			return v;
		end
		k = ph_stk[lvl_count-1];
		case (pat_stk[lvl_count-1])
			PAT_A: d = (k == 2'd0) ? DIR_UP : (k == 2'd1) ? DIR_RIGHT : DIR_DOWN;
			PAT_B: d = (k == 2'd0) ? DIR_RIGHT : (k == 2'd1) ? DIR_UP : DIR_LEFT;
			PAT_C: d = (k == 2'd0) ? DIR_LEFT : (k == 2'd1) ? DIR_DOWN : DIR_RIGHT;
			default: d = (k == 2'd0) ? DIR_DOWN : (k == 2'd1) ? DIR_LEFT : DIR_UP;
		endcase
		case (d)
			DIR_UP:    v.y = cell_len;
			DIR_RIGHT: v.x = cell_len;
			DIR_DOWN:  v.y = -cell_len;
			default:   v.x = -cell_len;
		endcase
		k = k + 2'd1;
		ph_stk[lvl_count-1] = k;
		if (lvl_count == 1 && k == 2'd3) begin
			walk_done = 1'b1;
			v.last    = 1'b1;
		end else begin
			descend(ord);
		end
		return v;
	endfunction

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			tx_gap   <= 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_vertices.insert(pending_vertices.size(), next_vertex(s_tdata[0]));
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					s_tvalid <= 1'b0;
					tx_gap   <= tx_gap - 1;
				end else if (restart_q.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {{(InDataW-1){1'b0}}, restart_q.pop_front()};
					tx_gap   <= tx_idle ? 0 : int'($urandom_range(0, 14));
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready      <= 1'b0;
			rx_wait       <= 0;
			long_hold_ack <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_vertices.size() == 0) begin
					$error("result beat with no expected vertex");
					error_count++;
				end else begin
					if (m_tdata[MoveW-1:0] !== pending_vertices[0].x) begin
						$error("move_x: expected %h, got %h",
							pending_vertices[0].x, m_tdata[MoveW-1:0]);
						error_count++;
					end
					if (m_tdata[2*MoveW-1:MoveW] !== pending_vertices[0].y) begin
						$error("move_y: expected %h, got %h",
							pending_vertices[0].y, m_tdata[2*MoveW-1:MoveW]);
						error_count++;
					end
					if (m_tuser[UserRelBit] !== pending_vertices[0].rel) begin
						$error("is_relative: expected %b, got %b",
							pending_vertices[0].rel, m_tuser[UserRelBit]);
						error_count++;
					end
					if (m_tlast !== pending_vertices[0].last) begin
						$error("is_last: expected %b, got %b",
							pending_vertices[0].last, m_tlast);
						error_count++;
					end
					if (m_tuser[UserPastBit] !== pending_vertices[0].past) begin
						$error("past_end: expected %b, got %b",
							pending_vertices[0].past, m_tuser[UserPastBit]);
						error_count++;
					end
					void'(pending_vertices.pop_front());
				end
			end
			if (long_hold_arm != long_hold_ack) begin
				long_hold_ack <= long_hold_arm;
				rx_wait       <= LongHold;
				m_tready      <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				rx_draw   = rx_idle ? 0 : int'($urandom_range(0, 14));
				rx_wait  <= rx_draw;
				m_tready <= (rx_draw == 0);
			end else if (rx_wait > 1) begin
				rx_wait <= rx_wait - 1;
			end else begin
				rx_wait  <= 0;
				m_tready <= 1'b1;
			end
		end
	end

	task automatic queue_requests(input logic restart, input int n);
		for (int i = 0; i < n; i++)
			restart_q.insert(restart_q.size(), restart);
	endtask

	task automatic wait_idle();
		while (restart_q.size() != 0 || s_tvalid || pending_vertices.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SideW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_CURVE_ORDER)
			cur_order = val[OrderW-1:0];
		else
			side_len = val;
		@(negedge clk);
	endtask

	initial begin
		int sent;
		int phase;
		int span;
		int n;
		int moves;
		int pick;
		logic [OrderW-1:0] ord;
		logic [OrderW-1:0] eff;
		logic [SideW-1:0] side;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Order zero after reset: the start vertex is also the last one.
		queue_requests(1'b1, 1);
		queue_requests(1'b0, 1);
		wait_idle();

		// Order one on the widest square, then a move past the end.
		write_reg(REG_CURVE_ORDER, 32'd1);
		write_reg(REG_SIDE_LENGTH, 32'hFFFF_FFFF);
		queue_requests(1'b1, 1);
		queue_requests(1'b0, 4);
		wait_idle();

		// An order above the maximum acts as the maximum.
		write_reg(REG_CURVE_ORDER, 32'd31);
		queue_requests(1'b1, 1);
		queue_requests(1'b0, 2);
		wait_idle();

		// Shrink order and side while the deep curve is still active.
		write_reg(REG_CURVE_ORDER, 32'd2);
		write_reg(REG_SIDE_LENGTH, 32'd0);
		queue_requests(1'b0, 2);
		wait_idle();

		sent  = 0;
		phase = 0;
		while (sent < RandomItems) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				ord = OrderW'($urandom_range(0, 3));
			else if (pick < 17)
				ord = OrderW'($urandom_range(4, 16));
			else
				ord = OrderW'($urandom_range(17, 31));
			pick = $urandom_range(0, 9);
			side = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
			write_reg(REG_CURVE_ORDER, {{(SideW-OrderW){1'b0}}, ord});
			write_reg(REG_SIDE_LENGTH, side);
			eff = (ord > OrderW'(MaxOrder)) ? OrderW'(MaxOrder) : ord;
			tx_idle = ($urandom_range(0, 3) == 0);
			rx_idle = ($urandom_range(0, 3) == 0);
			span = $urandom_range(30, 90);
			n = 0;
			while (n < span) begin
				if ($urandom_range(0, 9) < 7) begin
					// A whole small curve, sometimes overrun; deep curves only partly.
					if (eff <= 3)
						moves = (1 << (2 * eff)) - 1 + $urandom_range(0, 2);
					else
						moves = $urandom_range(1, 40);
					queue_requests(1'b1, 1);
					queue_requests(1'b0, moves);
					n += moves + 1;
				end else begin
					moves = $urandom_range(1, 8);
					for (int i = 0; i < moves; i++)
						restart_q.insert(restart_q.size(), 1'($urandom_range(0, 1)));
					n += moves;
				end
			end
			sent += n;
			// Stall the result side for a long stretch while requests keep coming.
			if (phase == 1)
				long_hold_arm = ~long_hold_arm;
			wait_idle();
			phase++;
		end

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
